[src/peer_wire_message_deframer_defines.svh]
// assertion helpers for the deframer core
// both expect clk and rst in scope
`ifndef PEER_WIRE_MESSAGE_DEFRAMER_DEFINES_SVH
`define PEER_WIRE_MESSAGE_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define PWMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pwmd_pkg.sv]
`default_nettype none
package pwmd_pkg;

  localparam int MAX_BLOCK_LEN_DEF = 16384;
  localparam int MAX_PIECES_DEF    = 1048576;
  localparam int HS_FIELD_LEN      = 20;
  localparam int NUM_PIECES_W      = 21;
  localparam int OFFSET_W          = 18;

  // message types
  localparam logic [7:0] TYPE_CHOKE          = 8'd0;
  localparam logic [7:0] TYPE_UNCHOKE        = 8'd1;
  localparam logic [7:0] TYPE_INTERESTED     = 8'd2;
  localparam logic [7:0] TYPE_NOT_INTERESTED = 8'd3;
  localparam logic [7:0] TYPE_HAVE           = 8'd4;
  localparam logic [7:0] TYPE_BITFIELD       = 8'd5;
  localparam logic [7:0] TYPE_REQUEST        = 8'd6;
  localparam logic [7:0] TYPE_PIECE          = 8'd7;
  localparam logic [7:0] TYPE_CANCEL         = 8'd8;
  localparam logic [7:0] TYPE_MAX            = 8'd8;

  // fixed lengths
  localparam logic [31:0] LEN_SIMPLE  = 32'd1;
  localparam logic [31:0] LEN_HAVE    = 32'd5;
  localparam logic [31:0] LEN_REQUEST = 32'd13;
  localparam logic [31:0] LEN_PIECE_HDR_MSG = 32'd9;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_PSTR   = 2'd1;
  localparam logic [1:0] ERR_TYPE   = 2'd2;
  localparam logic [1:0] ERR_LENGTH = 2'd3;

  typedef enum logic [6:0] {
    PH_PSTR      = 7'b0000001,
    PH_INFO_HASH = 7'b0000010,
    PH_PEER_ID   = 7'b0000100,
    PH_LENGTH    = 7'b0001000,
    PH_TYPE      = 7'b0010000,
    PH_PIECE_HDR = 7'b0100000,
    PH_BODY      = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]          phase;
    logic [7:0]          byte_out;
    logic [OFFSET_W-1:0] phase_offset;
    logic [7:0]          message_type;
    logic [31:0]         message_length;
    logic                keepalive;
    logic                word_ready;
    logic [31:0]         word_value;
    logic                handshake_done;
    logic                message_last;
    logic [1:0]          error_code;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_PSTR:      code = 3'd0;
      PH_INFO_HASH: code = 3'd1;
      PH_PEER_ID:   code = 3'd2;
      PH_LENGTH:    code = 3'd3;
      PH_TYPE:      code = 3'd4;
      PH_PIECE_HDR: code = 3'd5;
      PH_BODY:      code = 3'd6;
      default:      code = 3'd0;
    endcase
    return code;
  endfunction

  // protocol string: 0x13 then the protocol name
  function automatic logic [7:0] pstr_byte(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h13;
      5'd1:    c = "B";
      5'd2:    c = "i";
      5'd3:    c = "t";
      5'd4:    c = "T";
      5'd5:    c = "o";
      5'd6:    c = "r";
      5'd7:    c = "r";
      5'd8:    c = "e";
      5'd9:    c = "n";
      5'd10:   c = "t";
      5'd11:   c = " ";
      5'd12:   c = "p";
      5'd13:   c = "r";
      5'd14:   c = "o";
      5'd15:   c = "t";
      5'd16:   c = "o";
      5'd17:   c = "c";
      5'd18:   c = "o";
      5'd19:   c = "l";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[src/pwmd_cfg.sv]
`default_nettype none
module pwmd_cfg
  import pwmd_pkg::*;
#(
  parameter int MAX_PIECES = MAX_PIECES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output logic      [31:0]              bitfield_len
);

  localparam logic CFG_IDX_NUM_PIECES = 1'b0;

  logic [NUM_PIECES_W-1:0] num_pieces;
  logic [31:0]             wr_count;
  logic [31:0]             clamped;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_NUM_PIECES);

  // required bitfield length follows the count, worked out at write time
  always_comb begin
    wr_count = 32'(pwdata[NUM_PIECES_W-1:0]);
    clamped  = (wr_count > 32'(MAX_PIECES)) ? 32'(MAX_PIECES) : wr_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_pieces   <= '0;
      bitfield_len <= LEN_SIMPLE;
    end else if (wr_en) begin
      num_pieces   <= pwdata[NUM_PIECES_W-1:0];
      bitfield_len <= (clamped >> 3) + 32'(|clamped[2:0]) + LEN_SIMPLE;
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_NUM_PIECES) ? 32'(num_pieces) : 32'd0;

endmodule
`default_nettype wire

[src/pwmd_core.sv]
`default_nettype none
`include "peer_wire_message_deframer_defines.svh"
module pwmd_core
  import pwmd_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = MAX_BLOCK_LEN_DEF,
  parameter int COUNT_W       = 17
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        new_connection,
  input  wire logic [31:0] bitfield_len,
  input  wire logic        out_free,
  output logic             res_load,
  output result_t          res_next
);

  // input register
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_new;

  // parse state
  phase_t             parse_phase;
  logic [COUNT_W-1:0] byte_counter;
  logic [31:0]        length_register;
  logic [7:0]         type_register;
  logic [31:0]        word_shift;
  logic               dead;

  // state as seen by this word, after a connection restart
  phase_t             cur_phase;
  logic [COUNT_W-1:0] cur_cnt;
  logic [31:0]        cur_len;
  logic [7:0]         cur_type;
  logic [31:0]        cur_shift;
  logic               cur_dead;

  phase_t             phase_next;
  logic [COUNT_W-1:0] byte_counter_next;
  logic [31:0]        length_register_next;
  logic [7:0]         type_register_next;
  logic [31:0]        word_shift_next;
  logic               dead_next;

  logic [31:0] shifted;
  logic [31:0] body_len;
  logic [31:0] cnt_plus;
  logic        len_ok;
  logic [1:0]  type_err;
  logic        fire;

  assign fire     = inq_valid && out_free;
  assign in_ready = !inq_valid || out_free;
  assign res_load = fire;

  always_comb begin
    cur_phase = inq_new ? PH_PSTR : parse_phase;
    cur_cnt   = inq_new ? '0      : byte_counter;
    cur_len   = inq_new ? '0      : length_register;
    cur_type  = inq_new ? '0      : type_register;
    cur_shift = inq_new ? '0      : word_shift;
    cur_dead  = inq_new ? 1'b0    : dead;

    shifted  = {cur_shift[23:0], inq_byte};
    cnt_plus = 32'(cur_cnt) + 32'd1;
    body_len = (cur_type == TYPE_PIECE) ? cur_len - LEN_PIECE_HDR_MSG
                                        : cur_len - LEN_SIMPLE;

    // allowed length for the incoming type byte
    case (inq_byte)
      TYPE_CHOKE, TYPE_UNCHOKE, TYPE_INTERESTED, TYPE_NOT_INTERESTED:
        len_ok = (cur_len == LEN_SIMPLE);
      TYPE_HAVE:                 len_ok = (cur_len == LEN_HAVE);
      TYPE_BITFIELD:             len_ok = (cur_len == bitfield_len);
      TYPE_REQUEST, TYPE_CANCEL: len_ok = (cur_len == LEN_REQUEST);
      TYPE_PIECE:                len_ok = (cur_len >= LEN_PIECE_HDR_MSG) &&
                                          (cur_len <= 32'(MAX_BLOCK_LEN) + LEN_PIECE_HDR_MSG);
      default:                   len_ok = 1'b0;
    endcase

    phase_next           = cur_phase;
    byte_counter_next    = cur_cnt;
    length_register_next = cur_len;
    type_register_next   = cur_type;
    word_shift_next      = cur_shift;
    dead_next            = cur_dead;

    type_err = (cur_type > TYPE_MAX) ? ERR_TYPE : ERR_LENGTH;

    res_next                = '0;
    res_next.phase          = phase_code(cur_phase);
    res_next.byte_out       = inq_byte;
    res_next.phase_offset   = OFFSET_W'(cur_cnt);

    if (cur_dead) begin
      res_next.error_code = (cur_phase == PH_PSTR) ? ERR_PSTR : type_err;
    end else begin
      case (cur_phase)
        PH_PSTR: begin
          if ((32'(cur_cnt) >= 32'(HS_FIELD_LEN)) ||
              (inq_byte != pstr_byte(cur_cnt[4:0]))) begin
            dead_next           = 1'b1;
            res_next.error_code = ERR_PSTR;
          end else if (32'(cur_cnt) == 32'(HS_FIELD_LEN - 1)) begin
            phase_next        = PH_INFO_HASH;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = cur_cnt + 1'b1;
          end
        end
        PH_INFO_HASH, PH_PEER_ID: begin
          if (32'(cur_cnt) >= 32'(HS_FIELD_LEN - 1)) begin
            res_next.handshake_done = (cur_phase == PH_PEER_ID);
            phase_next        = (cur_phase == PH_PEER_ID) ? PH_LENGTH : PH_PEER_ID;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = cur_cnt + 1'b1;
          end
        end
        PH_LENGTH: begin
          word_shift_next = shifted;
          if (32'(cur_cnt) >= 32'd3) begin
            length_register_next = shifted;
            byte_counter_next    = '0;
            if (shifted == 32'd0) begin
              res_next.keepalive = 1'b1;
            end else begin
              phase_next = PH_TYPE;
            end
          end else begin
            byte_counter_next = cur_cnt + 1'b1;
          end
        end
        PH_TYPE: begin
          type_register_next = inq_byte;
          byte_counter_next  = '0;
          if (!len_ok) begin
            dead_next           = 1'b1;
            res_next.error_code = (inq_byte > TYPE_MAX) ? ERR_TYPE : ERR_LENGTH;
          end else if (cur_len == LEN_SIMPLE) begin
            res_next.message_last = 1'b1;
            phase_next            = PH_LENGTH;
          end else if (inq_byte == TYPE_PIECE) begin
            phase_next = PH_PIECE_HDR;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_PIECE_HDR: begin
          word_shift_next = shifted;
          if (cur_cnt[1:0] == 2'd3) begin
            res_next.word_ready = 1'b1;
            res_next.word_value = shifted;
          end
          if (32'(cur_cnt) >= 32'd7) begin
            byte_counter_next = '0;
            if (cur_len == LEN_PIECE_HDR_MSG) begin
              res_next.message_last = 1'b1;
              phase_next            = PH_LENGTH;
            end else begin
              phase_next = PH_BODY;
            end
          end else begin
            byte_counter_next = cur_cnt + 1'b1;
          end
        end
        PH_BODY: begin
          word_shift_next = shifted;
          if ((cur_cnt[1:0] == 2'd3) &&
              (cur_type == TYPE_HAVE || cur_type == TYPE_REQUEST ||
               cur_type == TYPE_CANCEL)) begin
            res_next.word_ready = 1'b1;
            res_next.word_value = shifted;
          end
          if (cnt_plus >= body_len) begin
            res_next.message_last = 1'b1;
            phase_next            = PH_LENGTH;
            byte_counter_next     = '0;
          end else begin
            byte_counter_next = cur_cnt + 1'b1;
          end
        end
        default: begin
          phase_next        = PH_PSTR;
          byte_counter_next = '0;
        end
      endcase
    end

    res_next.message_type   = type_register_next;
    res_next.message_length = length_register_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid       <= 1'b0;
      parse_phase     <= PH_PSTR;
      byte_counter    <= '0;
      length_register <= '0;
      type_register   <= '0;
      word_shift      <= '0;
      dead            <= 1'b0;
    end else begin
      if (in_ready) begin
        inq_valid <= in_valid;
      end
      if (fire) begin
        parse_phase     <= phase_next;
        byte_counter    <= byte_counter_next;
        length_register <= length_register_next;
        type_register   <= type_register_next;
        word_shift      <= word_shift_next;
        dead            <= dead_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= rx_byte;
      inq_new  <= new_connection;
    end
  end

  `PWMD_ASSERT_NXT(a_dead_freezes, fire && dead && !inq_new,
    $stable(parse_phase) && $stable(byte_counter) && $stable(length_register),
    "parse state moved while in error")
  `PWMD_ASSERT_IMP(a_err_no_flags, fire && res_next.error_code != ERR_NONE,
    !res_next.keepalive && !res_next.word_ready && !res_next.message_last &&
    !res_next.handshake_done,
    "flag raised alongside an error")
  `PWMD_ASSERT_IMP(a_word_in_msg, fire && res_next.word_ready,
    res_next.phase == phase_code(PH_PIECE_HDR) || res_next.phase == phase_code(PH_BODY),
    "word completed outside a message body")
  `PWMD_ASSERT_IMP(a_keepalive_len, fire && res_next.keepalive,
    res_next.message_length == 32'd0 && res_next.phase == phase_code(PH_LENGTH),
    "keepalive with nonzero length")

endmodule
`default_nettype wire

[src/pwmd_out.sv]
`default_nettype none
module pwmd_out
  import pwmd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_load,
  input  wire result_t res_next,
  output logic         out_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

[src/peer_wire_message_deframer.sv]
// an accepted word goes to the input register, its result word then to the result register
// throughput: one word per cycle unless out_ready stalls; parse state loop is unpipelined
// reset: synchronous active-high rst empties both registers and returns parsing to
//   the protocol string with no error; the piece total resets to zero
// new_connection on a word restarts parsing before that word, the piece total is kept
`default_nettype none
module peer_wire_message_deframer
  import pwmd_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = MAX_BLOCK_LEN_DEF,
  parameter int MAX_PIECES    = MAX_PIECES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // received bytes
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        new_connection,
  // per-byte results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       phase,
  output logic [7:0]       byte_out,
  output logic [17:0]      phase_offset,
  output logic [7:0]       message_type,
  output logic [31:0]      message_length,
  output logic             keepalive,
  output logic             word_ready,
  output logic [31:0]      word_value,
  output logic             handshake_done,
  output logic             message_last,
  output logic [1:0]       error_code
);

  // longest body the counter has to walk: a full block or the largest bitfield
  localparam int MAX_BITFIELD = (MAX_PIECES + 7) / 8;
  localparam int MAX_BODY     = (MAX_BLOCK_LEN > MAX_BITFIELD) ? MAX_BLOCK_LEN : MAX_BITFIELD;
  // at least five bits so the handshake fields can be counted
  localparam int COUNT_W      = ($clog2(MAX_BODY) > 5) ? $clog2(MAX_BODY) : 5;

  logic [31:0] bitfield_len;
  logic        out_free;
  logic        res_load;
  result_t     res_next;
  result_t     res;

  // register block, also precomputes the required bitfield length
  pwmd_cfg #(
    .MAX_PIECES (MAX_PIECES)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .bitfield_len (bitfield_len)
  );

  // input register, parse state and the per-byte decision logic
  pwmd_core #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .COUNT_W       (COUNT_W)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .new_connection (new_connection),
    .bitfield_len   (bitfield_len),
    .out_free       (out_free),
    .res_load       (res_load),
    .res_next       (res_next)
  );

  // result register; frees itself when the consumer takes the word
  pwmd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res_next  (res_next),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // unpack the result word onto its ports
  assign phase          = res.phase;
  assign byte_out       = res.byte_out;
  assign phase_offset   = res.phase_offset;
  assign message_type   = res.message_type;
  assign message_length = res.message_length;
  assign keepalive      = res.keepalive;
  assign word_ready     = res.word_ready;
  assign word_value     = res.word_value;
  assign handshake_done = res.handshake_done;
  assign message_last   = res.message_last;
  assign error_code     = res.error_code;

endmodule
`default_nettype wire
